/* rtl/pixel_format_to_rgb32_defines.svh */
// assertion macros for the pixel format converter
// expects clk and arst_n to be visible where a macro is used
`ifndef PIXEL_FORMAT_TO_RGB32_DEFINES_SVH
`define PIXEL_FORMAT_TO_RGB32_DEFINES_SVH

// property checked on every rising clock edge, off while in reset
`define PF_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// implication that must hold in the cycle after its trigger
`define PF_ASSERT_NEXT(label, trig, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (prop)) \
		else $error(msg);

`endif

/* rtl/pf2rgb_pkg.sv */
`timescale 1ns / 1ps
// types, constants and conversion functions for the pixel format converter
// no dependencies; used by pixel_format_to_rgb32
package pf2rgb_pkg;

	// source format register codes
	typedef enum logic [1:0] {
		FMT_YCC422 = 2'd0,
		FMT_RGB565 = 2'd1,
		FMT_RGB32  = 2'd2,
		FMT_UNSUP  = 2'd3
	} src_fmt_t;

	// status codes
	localparam logic ST_OK    = 1'b0;
	localparam logic ST_UNSUP = 1'b1;

	// register map
	localparam int unsigned PADDR_W  = 3;
	localparam logic [0:0] REG_FORMAT = 1'b0;

	// BT.601 studio range coefficients, Q10
	localparam logic signed [20:0] K_Y   = 21'sd1192;
	localparam logic signed [20:0] K_RCR = 21'sd1634;
	localparam logic signed [20:0] K_GCR = 21'sd833;
	localparam logic signed [20:0] K_GCB = 21'sd400;
	localparam logic signed [20:0] K_BCB = 21'sd2066;
	localparam logic signed [20:0] Q10_MAX = 21'sd261120;
	localparam logic signed [9:0]  Y_OFS = 10'sd16;
	localparam logic signed [9:0]  C_OFS = 10'sd128;
	localparam logic [7:0] ALPHA_OPAQUE = 8'hff;

	// one source word as four bytes
	typedef struct packed {
		logic [7:0] src_byte0;
		logic [7:0] src_byte1;
		logic [7:0] src_byte2;
		logic [7:0] src_byte3;
	} src_word_t;

	// result: up to two pixels plus count and status
	typedef struct packed {
		logic [7:0] blue0;
		logic [7:0] green0;
		logic [7:0] red0;
		logic [7:0] alpha0;
		logic [7:0] blue1;
		logic [7:0] green1;
		logic [7:0] red1;
		logic [7:0] alpha1;
		logic [1:0] pixel_count;
		logic       status;
	} pix_word_t;

	// one converted pixel
	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
		logic [7:0] alpha;
	} bgra_t;

	// clamp a Q10 sum to 0..255.0 and drop the fraction
	function automatic logic [7:0] q10_clamp(input logic signed [20:0] v);
		logic [7:0] res;
		if (v < 21'sd0) begin
			res = 8'd0;
		end else if (v > Q10_MAX) begin
			res = 8'hff;
		end else begin
			res = v[17:10];
		end
		return res;
	endfunction

	// one YCbCr sample to BGRA
	function automatic bgra_t ycc_pixel(input logic [7:0] y, input logic [7:0] cb,
			input logic [7:0] cr);
		logic signed [9:0]  yd;
		logic signed [9:0]  cbd;
		logic signed [9:0]  crd;
		logic signed [20:0] ys;
		bgra_t px;
		yd  = $signed({2'b00, y}) - Y_OFS;
		cbd = $signed({2'b00, cb}) - C_OFS;
		crd = $signed({2'b00, cr}) - C_OFS;
		ys  = K_Y * 21'(yd);
		px.blue  = q10_clamp(ys + K_BCB * 21'(cbd));
		px.green = q10_clamp(ys - K_GCR * 21'(crd) - K_GCB * 21'(cbd));
		px.red   = q10_clamp(ys + K_RCR * 21'(crd));
		px.alpha = ALPHA_OPAQUE;
		return px;
	endfunction

	// one RGB565 pixel to BGRA with bit replication
	function automatic bgra_t rgb565_pixel(input logic [7:0] lo, input logic [7:0] hi);
		logic [4:0] b5;
		logic [5:0] g6;
		logic [4:0] r5;
		bgra_t px;
		b5 = lo[4:0];
		g6 = {hi[2:0], lo[7:5]};
		r5 = hi[7:3];
		px.blue  = {b5, b5[4:2]};
		px.green = {g6, g6[5:4]};
		px.red   = {r5, r5[4:2]};
		px.alpha = ALPHA_OPAQUE;
		return px;
	endfunction

endpackage

/* rtl/pixel_format_to_rgb32.sv */
`timescale 1ns / 1ps
// pixel format converter top level: YCbCr 4:2:2, RGB565 or RGB32 words to BGRA pixels
// depends on pf2rgb_pkg and pixel_format_to_rgb32_defines.svh
//
// channel   direction  handshake               payload
// src       in         src_valid / src_stall   pf2rgb_pkg::src_word_t
// pix       out        pix_valid / pix_stall   pf2rgb_pkg::pix_word_t
// apb       in         psel/penable/pready     source_format at address 0
//
// pix_valid follows a src transfer through the input register, then the result register
// one word per cycle unless stalled; constant-coefficient multiply-add sets the stage delay
// arst_n clears both stage valids and sets the source format to YCbCr 4:2:2
// a stall on pix backs up through the result register and then the input register
`include "pixel_format_to_rgb32_defines.svh"

module pixel_format_to_rgb32 (
	input  logic                               clk,
	input  logic                               arst_n,
	// source words
	input  logic                               src_valid,
	output logic                               src_stall,
	input  pf2rgb_pkg::src_word_t              src,
	// converted pixels
	output logic                               pix_valid,
	input  logic                               pix_stall,
	output pf2rgb_pkg::pix_word_t              pix,
	// configuration
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [pf2rgb_pkg::PADDR_W-1:0]     paddr,
	input  logic [31:0]                        pwdata,
	output logic [31:0]                        prdata,
	output logic                               pready
);
	import pf2rgb_pkg::*;

	src_fmt_t  fmt_q;
	logic      valid_s1;
	src_word_t word_s1;
	src_fmt_t  fmt_s1;
	logic      valid_s2;
	pix_word_t pix_s2;
	logic      load_s1;
	logic      load_s2;
	logic      reg_wr;
	pix_word_t pix_next;
	bgra_t     px0;
	bgra_t     px1;

	// configuration register
	assign pready = 1'b1;
	assign reg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_FORMAT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q <= FMT_YCC422;
		end else if (reg_wr) begin
			fmt_q <= src_fmt_t'(pwdata[1:0]);
		end
	end

	always_comb begin
		prdata = 32'd0;
		if (paddr[2] == REG_FORMAT) begin
			prdata = {30'd0, fmt_q};
		end
	end

	// pipeline flow control
	assign load_s2   = valid_s1 && (!valid_s2 || !pix_stall);
	assign src_stall = valid_s1 && !load_s2;
	assign load_s1   = src_valid && !src_stall;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= 1'b1;
		end else if (load_s2) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			word_s1 <= src;
			fmt_s1  <= fmt_q;
		end
	end

	// per-format conversion
	always_comb begin
		pix_next = '0;
		px0      = '0;
		px1      = '0;
		case (fmt_s1)
			FMT_YCC422: begin
				px0 = ycc_pixel(word_s1.src_byte0, word_s1.src_byte1, word_s1.src_byte3);
				px1 = ycc_pixel(word_s1.src_byte2, word_s1.src_byte1, word_s1.src_byte3);
				pix_next.pixel_count = 2'd2;
			end
			FMT_RGB565: begin
				px0 = rgb565_pixel(word_s1.src_byte0, word_s1.src_byte1);
				px1 = rgb565_pixel(word_s1.src_byte2, word_s1.src_byte3);
				pix_next.pixel_count = 2'd2;
			end
			FMT_RGB32: begin
				px0 = {word_s1.src_byte0, word_s1.src_byte1, word_s1.src_byte2,
					word_s1.src_byte3};
				pix_next.pixel_count = 2'd1;
			end
			default: begin
				pix_next.status = ST_UNSUP;
			end
		endcase
		pix_next.blue0  = px0.blue;
		pix_next.green0 = px0.green;
		pix_next.red0   = px0.red;
		pix_next.alpha0 = px0.alpha;
		pix_next.blue1  = px1.blue;
		pix_next.green1 = px1.green;
		pix_next.red1   = px1.red;
		pix_next.alpha1 = px1.alpha;
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load_s2) begin
			valid_s2 <= 1'b1;
		end else if (!pix_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2) begin
			pix_s2 <= pix_next;
		end
	end

	assign pix_valid = valid_s2;
	assign pix       = pix_s2;

	// checks
	`PF_ASSERT(a_stall_only_when_full, src_stall |-> (valid_s1 && valid_s2), "stall with room")
	`PF_ASSERT_NEXT(a_s1_held, valid_s1 && !load_s2, valid_s1, "input stage item dropped")
	`PF_ASSERT_NEXT(a_unsup_result, load_s2 && fmt_s1 == FMT_UNSUP, pix.status == ST_UNSUP && pix.pixel_count == 2'd0, "bad unsupported result")
	`PF_ASSERT_NEXT(a_rgb32_single, load_s2 && fmt_s1 == FMT_RGB32, pix.pixel_count == 2'd1 && pix.alpha1 == 8'd0, "bad passthrough result")
	`PF_ASSERT_NEXT(a_ycc_opaque, load_s2 && fmt_s1 == FMT_YCC422, pix.alpha0 == ALPHA_OPAQUE && pix.alpha1 == ALPHA_OPAQUE, "ycc alpha not opaque")

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// self-checking testbench for pixel_format_to_rgb32: queued source words, clocked driver and monitor
// depends on pf2rgb_pkg and the pixel_format_to_rgb32 top level
module tb_top;
	import pf2rgb_pkg::*;

	// BT.601 studio range coefficients, round(c * 1024)
	localparam int C_LUMA   = 1192;
	localparam int C_CR_RED = 1634;
	localparam int C_CR_GRN = 833;
	localparam int C_CB_GRN = 400;
	localparam int C_CB_BLU = 2066;
	localparam int SAT_MAX  = 255 * 1024;

	// register addresses: the format register and the first unmapped slot
	localparam logic [PADDR_W-1:0] ADDR_FORMAT = 3'd0;
	localparam logic [PADDR_W-1:0] ADDR_UNUSED = 3'd4;

	localparam int STALL_LIMIT = 1000;
	localparam int LONG_HOLD   = 80;
	localparam int PHASE_WORDS = 125;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic src_valid = 1'b0;
	logic src_stall;
	src_word_t src = '0;
	logic pix_valid;
	logic pix_stall = 1'b0;
	pix_word_t pix;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	src_word_t words_to_send[$];
	pix_word_t pending_pixels[$];
	src_fmt_t cur_fmt = FMT_YCC422;
	int unsigned send_idle = 0;
	int unsigned rcv_idle = 0;
	int hold_request = 0;
	int mismatches = 0;
	int quiet_cycles = 0;
	logic [7:0] edge_bytes [14] = '{8'd0, 8'd1, 8'd15, 8'd16, 8'd17, 8'd127, 8'd128,
		8'd129, 8'd235, 8'd236, 8'd239, 8'd240, 8'd254, 8'd255};

	pixel_format_to_rgb32 u_top (
		.clk(clk), .arst_n(arst_n),
		.src_valid(src_valid), .src_stall(src_stall), .src(src),
		.pix_valid(pix_valid), .pix_stall(pix_stall), .pix(pix),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #5 clk = ~clk;

	// Q10 sum clamped to 0..255.0, fraction dropped
	function automatic logic [7:0] sat_q10(input int acc);
		if (acc < 0) begin
			return 8'd0;
		end else if (acc > SAT_MAX) begin
			return 8'hff;
		end
		return 8'(acc >>> 10);
	endfunction

	// one luma sample with shared chroma, packed as blue, green, red, alpha
	function automatic logic [31:0] ycc_to_bgra(input logic [7:0] y, input logic [7:0] cb,
			input logic [7:0] cr);
		int yd;
		int cbd;
		int crd;
		int luma;
		yd = int'(y);
		cbd = int'(cb);
		crd = int'(cr);
		yd = yd - 16;
		cbd = cbd - 128;
		crd = crd - 128;
		luma = C_LUMA * yd;
		return {sat_q10(luma + C_CB_BLU * cbd), sat_q10(luma - C_CR_GRN * crd - C_CB_GRN * cbd),
			sat_q10(luma + C_CR_RED * crd), 8'hff};
	endfunction

	// 565 pixel widened by replicating the top bits into the bottom
	function automatic logic [31:0] rgb565_to_bgra(input logic [7:0] lo, input logic [7:0] hi);
		logic [7:0] b8;
		logic [7:0] g8;
		logic [7:0] r8;
		b8 = lo & 8'h1f;
		g8 = (lo >> 5) | ((hi & 8'h07) << 3);
		r8 = hi & 8'hf8;
		return {(b8 << 3) | (b8 >> 2), (g8 << 2) | (g8 >> 4), r8 | (r8 >> 5), 8'hff};
	endfunction

	// expected result of one source word under a given format
	function automatic pix_word_t convert_word(input src_fmt_t fmt, input src_word_t w);
		pix_word_t r;
		r = '0;
		case (fmt)
			FMT_YCC422: begin
				{r.blue0, r.green0, r.red0, r.alpha0} =
					ycc_to_bgra(w.src_byte0, w.src_byte1, w.src_byte3);
				{r.blue1, r.green1, r.red1, r.alpha1} =
					ycc_to_bgra(w.src_byte2, w.src_byte1, w.src_byte3);
				r.pixel_count = 2'd2;
			end
			FMT_RGB565: begin
				{r.blue0, r.green0, r.red0, r.alpha0} = rgb565_to_bgra(w.src_byte0, w.src_byte1);
				{r.blue1, r.green1, r.red1, r.alpha1} = rgb565_to_bgra(w.src_byte2, w.src_byte3);
				r.pixel_count = 2'd2;
			end
			FMT_RGB32: begin
				{r.blue0, r.green0, r.red0, r.alpha0} = w;
				r.pixel_count = 2'd1;
			end
			default: begin
				r.status = ST_UNSUP;
			end
		endcase
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		if (mismatches < 40) begin
			$display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
		end
		mismatches++;
	endtask

	// field by field compare of one received result
	task automatic check_result(input pix_word_t got, input pix_word_t want);
		if (got.blue0 !== want.blue0)
			report_mismatch("blue0", int'(got.blue0), int'(want.blue0));
		if (got.green0 !== want.green0)
			report_mismatch("green0", int'(got.green0), int'(want.green0));
		if (got.red0 !== want.red0)
			report_mismatch("red0", int'(got.red0), int'(want.red0));
		if (got.alpha0 !== want.alpha0)
			report_mismatch("alpha0", int'(got.alpha0), int'(want.alpha0));
		if (got.blue1 !== want.blue1)
			report_mismatch("blue1", int'(got.blue1), int'(want.blue1));
		if (got.green1 !== want.green1)
			report_mismatch("green1", int'(got.green1), int'(want.green1));
		if (got.red1 !== want.red1)
			report_mismatch("red1", int'(got.red1), int'(want.red1));
		if (got.alpha1 !== want.alpha1)
			report_mismatch("alpha1", int'(got.alpha1), int'(want.alpha1));
		if (got.pixel_count !== want.pixel_count)
			report_mismatch("pixel_count", int'(got.pixel_count), int'(want.pixel_count));
		if (got.status !== want.status)
			report_mismatch("status", int'(got.status), int'(want.status));
	endtask

	// source driver: transfer on valid and not stall, then offer the next queued word
	always @(posedge clk) begin : driver
		if (!arst_n) begin
			src_valid <= 1'b0;
		end else begin
			if (src_valid && !src_stall) begin
				pending_pixels.push_back(convert_word(cur_fmt, src));
			end
			if (!src_valid || !src_stall) begin
				if (words_to_send.size() != 0 && $urandom_range(99) >= send_idle) begin
					src <= words_to_send.pop_front();
					src_valid <= 1'b1;
				end else begin
					src_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor and receiver stall generation
	always @(posedge clk) begin : monitor
		int hold_left;
		if (arst_n && pix_valid && !pix_stall) begin
			if (pending_pixels.size() == 0) begin
				report_mismatch("unexpected result", int'(pix.pixel_count), 0);
			end else begin
				check_result(pix, pending_pixels.pop_front());
			end
		end
		if (hold_left > 0) begin
			pix_stall <= 1'b1;
			hold_left--;
		end else if (hold_request != 0) begin
			hold_left = hold_request - 1;
			hold_request = 0;
			pix_stall <= 1'b1;
		end else begin
			pix_stall <= ($urandom_range(99) < rcv_idle);
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin : watchdog
		if ((src_valid && !src_stall) || (pix_valid && !pix_stall)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [31:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic apb_read(input logic [PADDR_W-1:0] addr, output logic [31:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= addr;
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		data = prdata;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// wait until nothing is queued, offered or outstanding
	task automatic wait_idle();
		@(negedge clk);
		while (words_to_send.size() != 0 || src_valid || pending_pixels.size() != 0)
			@(negedge clk);
	endtask

	// register write at idle, followed by a read-back against the predictor's copy
	task automatic write_reg(input logic [PADDR_W-1:0] addr, input logic [1:0] value);
		logic [31:0] readback;
		wait_idle();
		apb_write(addr, {30'($urandom() >> 2), value});
		if (addr == ADDR_FORMAT) begin
			cur_fmt = src_fmt_t'(value);
		end
		apb_read(ADDR_FORMAT, readback);
		if (readback[1:0] !== cur_fmt)
			report_mismatch("format readback", int'(readback[1:0]), int'(cur_fmt));
		@(negedge clk);
	endtask

	function automatic src_word_t mk(input logic [7:0] b0, input logic [7:0] b1,
			input logic [7:0] b2, input logic [7:0] b3);
		return '{b0, b1, b2, b3};
	endfunction

	// mostly uniform bytes, a quarter of words built from clamp and offset boundaries
	function automatic src_word_t random_word();
		src_word_t w;
		w = $urandom();
		if ($urandom_range(3) == 0) begin
			w = mk(edge_bytes[$urandom_range(13)], edge_bytes[$urandom_range(13)],
				edge_bytes[$urandom_range(13)], edge_bytes[$urandom_range(13)]);
		end
		return w;
	endfunction

	// one format setting: two bursts with a full drain between them
	task automatic run_phase(input src_fmt_t fmt, input bit long_hold);
		write_reg(ADDR_FORMAT, fmt);
		if (long_hold) hold_request = LONG_HOLD;
		repeat (PHASE_WORDS / 2) words_to_send.push_back(random_word());
		wait_idle();
		repeat (PHASE_WORDS - PHASE_WORDS / 2) words_to_send.push_back(random_word());
	endtask

	initial begin : stimulus
		src_fmt_t order [3][4];
		order = '{'{FMT_YCC422, FMT_RGB565, FMT_RGB32, FMT_UNSUP},
			'{FMT_UNSUP, FMT_RGB32, FMT_RGB565, FMT_YCC422},
			'{FMT_RGB565, FMT_UNSUP, FMT_YCC422, FMT_RGB32}};

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset format is YCbCr: black, white, chroma extremes
		words_to_send.push_back(mk(8'd16, 8'd128, 8'd235, 8'd128));
		words_to_send.push_back(mk(8'd0, 8'd0, 8'd255, 8'd255));
		words_to_send.push_back(mk(8'd255, 8'd255, 8'd0, 8'd0));
		words_to_send.push_back(mk(8'd255, 8'd0, 8'd128, 8'd255));
		words_to_send.push_back(mk(8'd0, 8'd255, 8'd128, 8'd0));

		// write to an unmapped register leaves the format alone
		write_reg(ADDR_UNUSED, FMT_UNSUP);
		words_to_send.push_back(mk(8'd128, 8'd128, 8'd128, 8'd128));
		words_to_send.push_back(mk(8'd235, 8'd240, 8'd17, 8'd16));

		// rgb565 replication
		write_reg(ADDR_FORMAT, FMT_RGB565);
		words_to_send.push_back(mk(8'h00, 8'h00, 8'hff, 8'hff));
		words_to_send.push_back(mk(8'h1f, 8'h00, 8'he0, 8'h07));
		words_to_send.push_back(mk(8'h00, 8'hf8, 8'h55, 8'haa));
		words_to_send.push_back(mk(8'h21, 8'h08, 8'h84, 8'h10));

		// passthrough: one pixel, second pixel zero
		write_reg(ADDR_FORMAT, FMT_RGB32);
		words_to_send.push_back(mk(8'h00, 8'hff, 8'ha5, 8'h5a));
		words_to_send.push_back(mk(8'hff, 8'h00, 8'h5a, 8'ha5));

		// unsupported format: empty result with error status
		write_reg(ADDR_FORMAT, FMT_UNSUP);
		words_to_send.push_back(mk(8'hff, 8'hff, 8'hff, 8'hff));
		words_to_send.push_back(mk(8'h00, 8'h00, 8'h00, 8'h00));

		// random part under three idling mixes
		for (int g = 0; g < 3; g++) begin
			wait_idle();
			send_idle = (g == 0) ? 16 : (g == 1) ? 46 : 0;
			rcv_idle = (g == 0) ? 46 : (g == 1) ? 16 : 0;
			for (int p = 0; p < 4; p++) begin
				run_phase(order[g][p], g == 2 && p == 1);
			end
		end

		wait_idle();
		repeat (10) @(posedge clk);
		if (mismatches == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
